### hdl/fprq_pkg.sv
// ============================================================================
// fprq_pkg
// Shared types, codes and the CRC-16/MODBUS byte update for the framed packet
// receiver queue.
// ============================================================================
`default_nettype none

package fprq_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_NUM_CHANNELS = 2;
    localparam int DEF_QUEUE_DEPTH  = 4;

    // Every queue slot owns a fixed span of payload storage.
    localparam int PAYLOAD_SPAN = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOCAL_ADDR = 2'd0;
    localparam logic [1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [1:0] CFG_HEAD_FIRST = 2'd2;
    localparam logic [1:0] CFG_HEAD_SECOND = 2'd3;

    typedef enum logic [1:0] {
        FN_RECEIVE = 2'd0,
        FN_READ    = 2'd1,
        FN_POP     = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        PH_HEAD1   = 4'd0,
        PH_HEAD2   = 4'd1,
        PH_DEST    = 4'd2,
        PH_SRC     = 4'd3,
        PH_TYPE    = 4'd4,
        PH_LEN     = 4'd5,
        PH_DATA    = 4'd6,
        PH_CRC_LO  = 4'd7,
        PH_CRC_BAD = 4'd8,
        PH_CRC_HI  = 4'd9
    } t_phase;

    typedef enum logic [3:0] {
        ST_BAD_CHANNEL = 4'd0,
        ST_FULL        = 4'd1,
        ST_BAD_BYTE    = 4'd2,
        ST_HEAD1       = 4'd3,
        ST_HEAD2       = 4'd4,
        ST_DEST        = 4'd5,
        ST_SRC         = 4'd6,
        ST_TYPE        = 4'd7,
        ST_LEN         = 4'd8,
        ST_DATA        = 4'd9,
        ST_CRC_LOW     = 4'd10,
        ST_CRC_FAIL    = 4'd11,
        ST_NOT_OURS    = 4'd12,
        ST_ACCEPTED    = 4'd13,
        ST_OK          = 4'd14,
        ST_EMPTY       = 4'd15
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CTX  = 2'd1,
        S_READ = 2'd2
    } t_state;

    // One byte of CRC-16/MODBUS, reflected, processed one bit a step.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/fprq_ram.sv
// ============================================================================
// fprq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module fprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/framed_packet_receiver_queue_unit.sv
// ============================================================================
// framed_packet_receiver_queue_unit
// A receive or pop word is taken while the block is idle; its result is
// registered at the end of the context cycle and the strobe is high for one
// cycle. A read also passes the read cycle before its result is registered.
// The receiver cannot stall the result. No new word is taken until the block
// is idle again, as set by the read-modify-write of the channel context memory.
// Reset (synchronous, active low) clears the controller, the config registers,
// the result strobe and the per-channel context valid bits; memories are not cleared.
// ============================================================================
`default_nettype none

module framed_packet_receiver_queue_unit #(
    parameter int NUM_CHANNELS = fprq_pkg::DEF_NUM_CHANNELS,
    parameter int QUEUE_DEPTH  = fprq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    // Command channel.
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_func,
    input  wire logic [1:0] i_channel,
    input  wire logic [7:0] i_byte_value,
    input  wire logic [7:0] i_data_index,

    // Configuration write port.
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,

    // Result channel: one word per command, valid for one cycle.
    output logic            o_strobe,
    output logic [3:0]      o_status,
    output logic [7:0]      o_dst_node,
    output logic [7:0]      o_src_node,
    output logic [7:0]      o_frame_type,
    output logic [7:0]      o_payload_len,
    output logic [7:0]      o_data_byte
);

    import fprq_pkg::*;

    // ------------------------------------------------------------------------
    // Derived sizes. A slot is one queue entry of one channel; each slot owns
    // PAYLOAD_SPAN bytes of the payload memory, addressed as {slot, byte}.
    // ------------------------------------------------------------------------
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHX_W  = (CH_W > 2) ? CH_W : 2;
    localparam int QI_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = NUM_CHANNELS * QUEUE_DEPTH;
    localparam int SL_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PDEPTH = SLOTS * PAYLOAD_SPAN;
    localparam int PA_W   = $clog2(PDEPTH);

    // Per-channel context, held in one word of the context memory. The header
    // bytes are collected here and written to the header memory in one go
    // when the length byte arrives.
    typedef struct packed {
        t_phase            phase;
        logic [7:0]        count;
        logic [15:0]       crc;
        logic [QI_W-1:0]   head;
        logic [QI_W-1:0]   tail;
        logic [FC_W-1:0]   fcount;
        logic [7:0]        dest;
        logic [7:0]        src;
        logic [7:0]        ftype;
        logic [7:0]        len;
    } t_ctx;

    localparam int CTX_W = $bits(t_ctx);

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic [7:0] r_local_addr;
    logic [7:0] r_bcast_addr;
    logic [7:0] r_head_first;
    logic [7:0] r_head_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr  <= 8'd0;
            r_bcast_addr  <= 8'd255;
            r_head_first  <= 8'd0;
            r_head_second <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOCAL_ADDR:  r_local_addr  <= i_cfg_data;
                CFG_BCAST_ADDR:  r_bcast_addr  <= i_cfg_data;
                CFG_HEAD_FIRST:  r_head_first  <= i_cfg_data;
                CFG_HEAD_SECOND: r_head_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Command capture. The context memory is read at the accepting edge, so
    // its data is ready in the following cycle.
    // ------------------------------------------------------------------------
    t_state           r_state;
    t_state           n_state;
    t_func            r_func;
    logic             r_ch_bad;
    logic [CH_W-1:0]  r_ch;
    logic [7:0]       r_byte;
    logic [7:0]       r_idx;

    logic             accept;
    logic [CHX_W-1:0] ch_ext;
    logic [CH_W-1:0]  ch_idx;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign ch_ext = CHX_W'(i_channel);
    assign ch_idx = ch_ext[CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= t_func'(i_func);
            r_ch_bad <= (32'(i_channel) >= NUM_CHANNELS);
            r_ch     <= ch_idx;
            r_byte   <= i_byte_value;
            r_idx    <= i_data_index;
        end
    end

    // ------------------------------------------------------------------------
    // Memories. The context memory has one entry per channel; a channel that
    // was never written reads as its reset context through its valid bit.
    // ------------------------------------------------------------------------
    logic                    ctx_we;
    t_ctx                    ctx_wdata;
    logic [CTX_W-1:0]        ctx_rdata;
    logic [NUM_CHANNELS-1:0] r_ctx_valid;

    logic                    hdr_we;
    logic [SL_W-1:0]         hdr_waddr;
    logic [31:0]             hdr_wdata;
    logic [SL_W-1:0]         hdr_raddr;
    logic [31:0]             hdr_rdata;

    logic                    pay_we;
    logic [PA_W-1:0]         pay_waddr;
    logic [PA_W-1:0]         pay_raddr;
    logic [7:0]              pay_rdata;

    fprq_ram #(
        .WIDTH (CTX_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ctx_we),
        .i_waddr (r_ch),
        .i_wdata (ctx_wdata),
        .i_raddr (ch_idx),
        .o_rdata (ctx_rdata)
    );

    fprq_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (hdr_waddr),
        .i_wdata (hdr_wdata),
        .i_raddr (hdr_raddr),
        .o_rdata (hdr_rdata)
    );

    fprq_ram #(
        .WIDTH (8),
        .DEPTH (PDEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (r_byte),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_valid <= '0;
        end else if (ctx_we) begin
            r_ctx_valid[r_ch] <= 1'b1;
        end
    end

    // Current context: memory word, or the reset context if never written.
    t_ctx ctx_init;
    t_ctx ctx_cur;

    always_comb begin
        ctx_init       = '0;
        ctx_init.phase = PH_HEAD1;
        ctx_init.crc   = CRC_INIT;
        ctx_cur        = r_ctx_valid[r_ch] ? t_ctx'(ctx_rdata) : ctx_init;
    end

    // Slot numbers of the tail (being filled) and the head (being read).
    logic [SL_W-1:0]  slot_tail;
    logic [SL_W-1:0]  slot_head;
    logic [15:0]      crc_next;
    logic [7:0]       count_inc;
    logic [QI_W-1:0]  tail_adv;
    logic [QI_W-1:0]  head_adv;

    assign slot_tail = SL_W'(32'(r_ch) * QUEUE_DEPTH + 32'(ctx_cur.tail));
    assign slot_head = SL_W'(32'(r_ch) * QUEUE_DEPTH + 32'(ctx_cur.head));
    assign crc_next  = crc16_update(ctx_cur.crc, r_byte);
    assign count_inc = ctx_cur.count + 8'd1;
    assign tail_adv  = (ctx_cur.tail == QI_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : ctx_cur.tail + 1'b1;
    assign head_adv  = (ctx_cur.head == QI_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : ctx_cur.head + 1'b1;

    // Header and payload addresses. The read addresses matter only in the
    // context cycle of a read, when the memories capture them.
    assign hdr_waddr = slot_tail;
    assign hdr_raddr = slot_head;
    assign pay_waddr = PA_W'({slot_tail, ctx_cur.count});
    assign pay_raddr = PA_W'({slot_head, r_idx});

    // ------------------------------------------------------------------------
    // Result registers.
    // ------------------------------------------------------------------------
    logic       r_strobe;
    t_status    r_status;
    logic [7:0] r_dst_node;
    logic [7:0] r_src_node;
    logic [7:0] r_frame_type;
    logic [7:0] r_payload_len;
    logic [7:0] r_data_byte;

    logic       n_strobe;
    t_status    n_status;
    logic [7:0] n_dst_node;
    logic [7:0] n_src_node;
    logic [7:0] n_frame_type;
    logic [7:0] n_payload_len;
    logic [7:0] n_data_byte;

    // ------------------------------------------------------------------------
    // Controller: next state, memory writes and the result word.
    // In the context cycle a receive, or a pop of a non-empty queue, on a valid
    // channel rewrites its word; a read then fetches header and payload data.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        ctx_we        = 1'b0;
        ctx_wdata     = ctx_cur;
        hdr_we        = 1'b0;
        hdr_wdata     = {r_byte, ctx_cur.ftype, ctx_cur.src, ctx_cur.dest};
        pay_we        = 1'b0;
        n_strobe      = 1'b0;
        n_status      = ST_BAD_CHANNEL;
        n_dst_node    = 8'd0;
        n_src_node    = 8'd0;
        n_frame_type  = 8'd0;
        n_payload_len = 8'd0;
        n_data_byte   = 8'd0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CTX;
                end
            end

            S_CTX: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                if (r_ch_bad || r_func == FN_NONE) begin
                    n_status = ST_BAD_CHANNEL;
                end else if (r_func == FN_RECEIVE) begin
                    ctx_we = 1'b1;
                    if (ctx_cur.fcount == FC_W'(QUEUE_DEPTH)) begin
                        // Queue full: the byte is refused and nothing moves.
                        n_status = ST_FULL;
                    end else begin
                        case (ctx_cur.phase)
                            PH_HEAD1: begin
                                if (r_byte == r_head_first) begin
                                    ctx_wdata.phase = PH_HEAD2;
                                    n_status        = ST_HEAD1;
                                end else begin
                                    n_status = ST_BAD_BYTE;
                                end
                            end
                            PH_HEAD2: begin
                                if (r_byte == r_head_second) begin
                                    ctx_wdata.phase = PH_DEST;
                                    n_status        = ST_HEAD2;
                                end else begin
                                    ctx_wdata.phase = PH_HEAD1;
                                    n_status        = ST_BAD_BYTE;
                                end
                            end
                            PH_DEST: begin
                                ctx_wdata.dest  = r_byte;
                                ctx_wdata.crc   = crc_next;
                                ctx_wdata.phase = PH_SRC;
                                n_status        = ST_DEST;
                            end
                            PH_SRC: begin
                                ctx_wdata.src   = r_byte;
                                ctx_wdata.crc   = crc_next;
                                ctx_wdata.phase = PH_TYPE;
                                n_status        = ST_SRC;
                            end
                            PH_TYPE: begin
                                ctx_wdata.ftype = r_byte;
                                ctx_wdata.crc   = crc_next;
                                ctx_wdata.phase = PH_LEN;
                                n_status        = ST_TYPE;
                            end
                            PH_LEN: begin
                                // The whole header goes to the tail slot now.
                                hdr_we          = 1'b1;
                                ctx_wdata.len   = r_byte;
                                ctx_wdata.crc   = crc_next;
                                ctx_wdata.count = 8'd0;
                                ctx_wdata.phase = (r_byte == 8'd0) ? PH_CRC_LO : PH_DATA;
                                n_status        = ST_LEN;
                            end
                            PH_DATA: begin
                                pay_we        = 1'b1;
                                ctx_wdata.crc = crc_next;
                                if (count_inc >= ctx_cur.len) begin
                                    ctx_wdata.phase = PH_CRC_LO;
                                    ctx_wdata.count = 8'd0;
                                end else begin
                                    ctx_wdata.count = count_inc;
                                end
                                n_status = ST_DATA;
                            end
                            PH_CRC_LO: begin
                                // A mismatch is only remembered here; it is
                                // reported with the high byte.
                                ctx_wdata.phase = (ctx_cur.crc[7:0] == r_byte) ? PH_CRC_HI
                                                                               : PH_CRC_BAD;
                                n_status        = ST_CRC_LOW;
                            end
                            PH_CRC_HI: begin
                                if (ctx_cur.crc[15:8] != r_byte) begin
                                    n_status = ST_CRC_FAIL;
                                end else if (ctx_cur.dest == r_local_addr ||
                                             ctx_cur.dest == r_bcast_addr) begin
                                    ctx_wdata.tail   = tail_adv;
                                    ctx_wdata.fcount = ctx_cur.fcount + 1'b1;
                                    n_status         = ST_ACCEPTED;
                                end else begin
                                    n_status = ST_NOT_OURS;
                                end
                                ctx_wdata.phase = PH_HEAD1;
                                ctx_wdata.crc   = CRC_INIT;
                            end
                            default: begin
                                // Low CRC byte was wrong: the high byte ends
                                // the frame as a CRC failure.
                                ctx_wdata.phase = PH_HEAD1;
                                ctx_wdata.crc   = CRC_INIT;
                                n_status        = ST_CRC_FAIL;
                            end
                        endcase
                    end
                end else if (ctx_cur.fcount == '0) begin
                    n_status = ST_EMPTY;
                end else if (r_func == FN_READ) begin
                    // Header and payload reads were issued this cycle.
                    n_state  = S_READ;
                    n_strobe = 1'b0;
                end else begin
                    ctx_we           = 1'b1;
                    ctx_wdata.head   = head_adv;
                    ctx_wdata.fcount = ctx_cur.fcount - 1'b1;
                    n_status         = ST_OK;
                end
            end

            S_READ: begin
                n_state       = S_IDLE;
                n_strobe      = 1'b1;
                n_status      = ST_OK;
                n_dst_node    = hdr_rdata[7:0];
                n_src_node    = hdr_rdata[15:8];
                n_frame_type  = hdr_rdata[23:16];
                n_payload_len = hdr_rdata[31:24];
                n_data_byte   = (r_idx < hdr_rdata[31:24]) ? pay_rdata : 8'd0;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_dst_node    <= n_dst_node;
        r_src_node    <= n_src_node;
        r_frame_type  <= n_frame_type;
        r_payload_len <= n_payload_len;
        r_data_byte   <= n_data_byte;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_dst_node    = r_dst_node;
    assign o_src_node    = r_src_node;
    assign o_frame_type  = r_frame_type;
    assign o_payload_len = r_payload_len;
    assign o_data_byte   = r_data_byte;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // An accepted command always moves to the context cycle.
    a_accept_to_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CTX))
        else $error("accepted command did not enter the context cycle");

    // A result word only follows a context or read cycle.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(r_state) == S_CTX || $past(r_state) == S_READ))
        else $error("result strobe without a preceding command cycle");

    // The frame count written back never exceeds the queue depth.
    a_fcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctx_we |-> (32'(ctx_wdata.fcount) <= QUEUE_DEPTH))
        else $error("frame count beyond queue depth");

endmodule

`default_nettype wire

### tb/sv/framed_packet_receiver_queue_unit_tb.sv
// ============================================================================
// framed_packet_receiver_queue_unit_tb
// Self-checking bench for the framed packet receiver queue. Frames with a
// CRC-16/MODBUS trailer are fed a word at a time on two channels. Reads, pops
// and stray words are mixed in between. A behavioural model of the deframer
// and its frame queues predicts every result word, and a checker process
// compares each strobed result with the oldest prediction.
// ============================================================================
module framed_packet_receiver_queue_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fprq_pkg::*;

    localparam int NCH         = DEF_NUM_CHANNELS;
    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_LEN   = 7;
    localparam int MAX_GAP     = 20;
    localparam int CYCLE_LIMIT = 300000;

    // Ways in which a generated frame may be spoilt on purpose.
    typedef enum int {
        FAULT_NONE,
        FAULT_CRC_LO,
        FAULT_CRC_HI,
        FAULT_HEAD,
        FAULT_TRUNCATE
    } t_frame_fault;

    // One predicted result word.
    typedef struct {
        t_status    status;
        logic [7:0] dest;
        logic [7:0] src;
        logic [7:0] ftype;
        logic [7:0] len;
        logic [7:0] data;
    } t_outcome;

    // ------------------------------------------------------------------
    // Signals to and from the block. Every input has a known value from
    // time zero.
    // ------------------------------------------------------------------
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       start        = 1'b0;
    logic       busy;
    logic [1:0] i_func       = FN_RECEIVE;
    logic [1:0] i_channel    = 2'd0;
    logic [7:0] i_byte_value = 8'h00;
    logic [7:0] i_data_index = 8'h00;
    logic       i_cfg_we     = 1'b0;
    logic [1:0] i_cfg_index  = CFG_LOCAL_ADDR;
    logic [7:0] i_cfg_data   = 8'h00;
    logic       o_strobe;
    logic [3:0] o_status;
    logic [7:0] o_dst_node;
    logic [7:0] o_src_node;
    logic [7:0] o_frame_type;
    logic [7:0] o_payload_len;
    logic [7:0] o_data_byte;

    // ------------------------------------------------------------------
    // Bench bookkeeping.
    // ------------------------------------------------------------------
    t_outcome pending_results [$];
    int       n_errors        = 0;
    int       words_sent      = 0;
    int       cycle_count     = 0;
    int       sender_idle_pct = 0;

    // ------------------------------------------------------------------
    // Model state: register copies, per-channel deframer state and the
    // frame queues with their header and payload slots.
    // ------------------------------------------------------------------
    logic [7:0]  cfg_node;
    logic [7:0]  cfg_bcast;
    logic [7:0]  cfg_head1;
    logic [7:0]  cfg_head2;

    t_phase      rx_phase  [NCH];
    logic [7:0]  rx_count  [NCH];
    logic [15:0] rx_crc    [NCH];
    int          q_head    [NCH];
    int          q_tail    [NCH];
    int          q_fill    [NCH];
    logic [7:0]  slot_dest [NCH][DEPTH];
    logic [7:0]  slot_src  [NCH][DEPTH];
    logic [7:0]  slot_type [NCH][DEPTH];
    logic [7:0]  slot_len  [NCH][DEPTH];
    logic [7:0]  slot_data [NCH][DEPTH][PAYLOAD_SPAN];

    // Brings the model to its state just after reset.
    function automatic void clear_model();
        cfg_node  = 8'h00;
        cfg_bcast = 8'hFF;
        cfg_head1 = 8'h00;
        cfg_head2 = 8'h00;
        for (int c = 0; c < NCH; c++) begin
            rx_phase[c] = PH_HEAD1;
            rx_count[c] = 8'h00;
            rx_crc[c]   = CRC_INIT;
            q_head[c]   = 0;
            q_tail[c]   = 0;
            q_fill[c]   = 0;
        end
    endfunction

    // Reflected CRC-16 fed one message bit at a time, least significant
    // bit first; this is the same code as xoring the whole byte in first.
    function automatic logic [15:0] modbus_crc_step(logic [15:0] acc, logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb  = acc[0] ^ b[k];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // One stream byte through the deframer of a valid channel.
    function automatic t_status take_stream_byte(int ch, logic [7:0] b);
        int      slot;
        t_status st;
        slot = q_tail[ch];
        st   = ST_CRC_FAIL;
        // A full queue refuses the byte and leaves the phase alone.
        if (q_fill[ch] >= DEPTH) begin
            return ST_FULL;
        end
        case (rx_phase[ch])
            PH_HEAD1: begin
                if (b == cfg_head1) begin
                    rx_phase[ch] = PH_HEAD2;
                    st = ST_HEAD1;
                end else begin
                    st = ST_BAD_BYTE;
                end
            end
            PH_HEAD2: begin
                if (b == cfg_head2) begin
                    rx_phase[ch] = PH_DEST;
                    st = ST_HEAD2;
                end else begin
                    rx_phase[ch] = PH_HEAD1;
                    st = ST_BAD_BYTE;
                end
            end
            PH_DEST: begin
                slot_dest[ch][slot] = b;
                rx_crc[ch]   = modbus_crc_step(rx_crc[ch], b);
                rx_phase[ch] = PH_SRC;
                st = ST_DEST;
            end
            PH_SRC: begin
                slot_src[ch][slot] = b;
                rx_crc[ch]   = modbus_crc_step(rx_crc[ch], b);
                rx_phase[ch] = PH_TYPE;
                st = ST_SRC;
            end
            PH_TYPE: begin
                slot_type[ch][slot] = b;
                rx_crc[ch]   = modbus_crc_step(rx_crc[ch], b);
                rx_phase[ch] = PH_LEN;
                st = ST_TYPE;
            end
            PH_LEN: begin
                // An empty payload skips straight to the CRC.
                slot_len[ch][slot] = b;
                rx_crc[ch]   = modbus_crc_step(rx_crc[ch], b);
                rx_count[ch] = 8'h00;
                rx_phase[ch] = (b == 8'h00) ? PH_CRC_LO : PH_DATA;
                st = ST_LEN;
            end
            PH_DATA: begin
                slot_data[ch][slot][rx_count[ch]] = b;
                rx_crc[ch]   = modbus_crc_step(rx_crc[ch], b);
                rx_count[ch] = rx_count[ch] + 8'd1;
                if (rx_count[ch] >= slot_len[ch][slot]) begin
                    rx_phase[ch] = PH_CRC_LO;
                    rx_count[ch] = 8'h00;
                end
                st = ST_DATA;
            end
            PH_CRC_LO: begin
                // A wrong low byte is still reported as a CRC low word; the
                // high byte that follows then fails whatever it holds.
                rx_phase[ch] = (rx_crc[ch][7:0] == b) ? PH_CRC_HI : PH_CRC_BAD;
                st = ST_CRC_LOW;
            end
            PH_CRC_HI: begin
                if (rx_crc[ch][15:8] != b) begin
                    st = ST_CRC_FAIL;
                end else if (slot_dest[ch][slot] == cfg_node ||
                             slot_dest[ch][slot] == cfg_bcast) begin
                    q_tail[ch] = (q_tail[ch] + 1) % DEPTH;
                    q_fill[ch] = q_fill[ch] + 1;
                    st = ST_ACCEPTED;
                end else begin
                    st = ST_NOT_OURS;
                end
                rx_phase[ch] = PH_HEAD1;
                rx_crc[ch]   = CRC_INIT;
            end
            default: begin
                rx_phase[ch] = PH_HEAD1;
                rx_crc[ch]   = CRC_INIT;
                st = ST_CRC_FAIL;
            end
        endcase
        return st;
    endfunction

    // Works out the result word of one accepted command word and moves the
    // model on.
    function automatic t_outcome predict_outcome(t_func fn, logic [1:0] ch,
                                                 logic [7:0] b, logic [7:0] idx);
        t_outcome r;
        int       slot;
        r.status = ST_BAD_CHANNEL;
        r.dest   = 8'h00;
        r.src    = 8'h00;
        r.ftype  = 8'h00;
        r.len    = 8'h00;
        r.data   = 8'h00;
        if (int'(ch) >= NCH || fn == FN_NONE) begin
            r.status = ST_BAD_CHANNEL;
        end else if (fn == FN_RECEIVE) begin
            r.status = take_stream_byte(int'(ch), b);
        end else if (q_fill[ch] == 0) begin
            r.status = ST_EMPTY;
        end else if (fn == FN_READ) begin
            slot    = q_head[ch];
            r.dest  = slot_dest[ch][slot];
            r.src   = slot_src[ch][slot];
            r.ftype = slot_type[ch][slot];
            r.len   = slot_len[ch][slot];
            r.data  = (idx < r.len) ? slot_data[ch][slot][idx] : 8'h00;
            r.status = ST_OK;
        end else begin
            q_head[ch] = (q_head[ch] + 1) % DEPTH;
            q_fill[ch] = q_fill[ch] - 1;
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks. All of them start and end on a rising clock edge.
    // ------------------------------------------------------------------

    // Offers one command word, with an optional random gap before it, and
    // records the expected result once the word has been taken. Start is
    // left high so that a following word goes out without a bubble.
    task automatic send_word(t_func fn, logic [1:0] ch, logic [7:0] b, logic [7:0] idx);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        start        <= 1'b1;
        i_func       <= fn;
        i_channel    <= ch;
        i_byte_value <= b;
        i_data_index <= idx;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_outcome(fn, ch, b, idx));
        words_sent++;
    endtask

    // Stops sending and lets every outstanding result word arrive, then
    // lets the block settle.
    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        case (idx)
            CFG_LOCAL_ADDR:  cfg_node  = v;
            CFG_BCAST_ADDR:  cfg_bcast = v;
            CFG_HEAD_FIRST:  cfg_head1 = v;
            default:         cfg_head2 = v;
        endcase
        @(posedge i_clk);
    endtask

    // Registers only change while the block has nothing in flight.
    task automatic apply_settings(logic [7:0] node, logic [7:0] bcast,
                                  logic [7:0] h1, logic [7:0] h2);
        wait_quiet();
        write_register(CFG_LOCAL_ADDR, node);
        write_register(CFG_BCAST_ADDR, bcast);
        write_register(CFG_HEAD_FIRST, h1);
        write_register(CFG_HEAD_SECOND, h2);
        i_cfg_we <= 1'b0;
    endtask

    // Reads the head frame of a channel, mostly at an index inside its
    // payload, sometimes exactly at its length, otherwise anywhere.
    task automatic read_word(int ch);
        logic [7:0] idx;
        logic [7:0] len;
        int         r;
        r   = $urandom_range(0, 9);
        idx = 8'($urandom);
        if (q_fill[ch] != 0 && r >= 4) begin
            len = slot_len[ch][q_head[ch]];
            if (r == 4 || len == 0) begin
                idx = len;
            end else begin
                idx = 8'($urandom_range(0, len - 1));
            end
        end
        send_word(FN_READ, 2'(ch), 8'($urandom), idx);
    endtask

    // A word that does not belong to the frame being sent on channel ch.
    task automatic send_noise_word(int ch);
        case ($urandom_range(0, 9))
            0, 1:    send_word(FN_NONE, 2'($urandom), 8'($urandom), 8'($urandom));
            2, 3:    send_word(t_func'($urandom_range(0, 3)), 2'($urandom_range(NCH, 3)),
                               8'($urandom), 8'($urandom));
            4, 5, 6: read_word($urandom_range(0, NCH - 1));
            7:       send_word(FN_POP, 2'($urandom_range(0, NCH - 1)), 8'($urandom),
                               8'($urandom));
            default: send_word(FN_RECEIVE, 2'((ch + 1) % NCH), 8'($urandom), 8'($urandom));
        endcase
    endtask

    // Brings a channel left part way through a frame back to waiting for a
    // head, unless its queue is full. A zero length byte keeps the way back short.
    task automatic flush_channel(int ch);
        while (rx_phase[ch] != PH_HEAD1 && q_fill[ch] < DEPTH) begin
            send_word(FN_RECEIVE, 2'(ch), (rx_phase[ch] == PH_LEN) ? 8'h00 : 8'($urandom),
                      8'($urandom));
        end
    endtask

    // Builds a whole frame with random content and sends it byte by byte,
    // spoilt as asked and, when noisy, with foreign words slipped in.
    task automatic send_frame(int ch, logic [7:0] dest, int len, t_frame_fault fault,
                              bit noisy);
        logic [7:0]  bytes [$];
        logic [15:0] crc;
        int          cut;
        flush_channel(ch);
        bytes = {};
        bytes.push_back(cfg_head1);
        bytes.push_back(cfg_head2);
        bytes.push_back(dest);
        bytes.push_back(8'($urandom));
        bytes.push_back(8'($urandom));
        bytes.push_back(len[7:0]);
        for (int i = 0; i < len; i++) begin
            bytes.push_back(8'($urandom));
        end
        crc = CRC_INIT;
        for (int i = 2; i < bytes.size(); i++) begin
            crc = modbus_crc_step(crc, bytes[i]);
        end
        bytes.push_back(crc[7:0]);
        bytes.push_back(crc[15:8]);
        cut = bytes.size();
        case (fault)
            FAULT_CRC_LO:   bytes[cut - 2] ^= 8'($urandom_range(1, 255));
            FAULT_CRC_HI:   bytes[cut - 1] ^= 8'($urandom_range(1, 255));
            FAULT_HEAD:     bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            FAULT_TRUNCATE: cut = $urandom_range(2, cut - 2);
            default: ;
        endcase
        for (int i = 0; i < cut; i++) begin
            if (noisy && $urandom_range(0, 99) < 8) begin
                send_noise_word(ch);
            end
            send_word(FN_RECEIVE, 2'(ch), bytes[i], 8'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_dest();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return cfg_node;
        end else if (r < 75) begin
            return cfg_bcast;
        end
        return 8'($urandom);
    endfunction

    // Mostly short payloads; now and then a long one.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 999);
        if (r < 5) begin
            return $urandom_range(200, 255);
        end else if (r < 150) begin
            return $urandom_range(7, 40);
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic t_frame_fault pick_fault();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return FAULT_NONE;
        end else if (r < 83) begin
            return FAULT_CRC_LO;
        end else if (r < 90) begin
            return FAULT_CRC_HI;
        end else if (r < 95) begin
            return FAULT_HEAD;
        end
        return FAULT_TRUNCATE;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Short hand-made sequence on the reset register values: bad channel,
    // the unused function code, read and pop of an empty queue, both ways
    // of losing the head, a zero length frame whose CRC low byte is wrong,
    // and a good broadcast frame read inside and past its payload.
    task automatic test_directed();
        sender_idle_pct = 0;
        send_word(FN_RECEIVE, 2'd3, 8'hFF, 8'hFF);
        send_word(FN_NONE, 2'd0, 8'h00, 8'h00);
        send_word(FN_READ, 2'd0, 8'h00, 8'h00);
        send_word(FN_POP, 2'd1, 8'h00, 8'h00);
        send_word(FN_RECEIVE, 2'd0, 8'h55, 8'h00);
        send_word(FN_RECEIVE, 2'd0, cfg_head1, 8'h00);
        send_word(FN_RECEIVE, 2'd0, 8'h77, 8'h00);
        send_frame(0, cfg_node, 0, FAULT_CRC_LO, 1'b0);
        send_frame(1, cfg_bcast, 1, FAULT_NONE, 1'b0);
        send_word(FN_READ, 2'd1, 8'h00, 8'h00);
        send_word(FN_READ, 2'd1, 8'hFF, 8'hFF);
        send_word(FN_POP, 2'd1, 8'hFF, 8'h00);
    endtask

    // Mostly well formed frames with random content on random channels,
    // broken frames and stray words among them, and reads and pops that
    // keep the queues moving between empty and full.
    task automatic test_random_traffic(int count, int idle_pct);
        int ch;
        int r;
        int stop;
        sender_idle_pct = idle_pct;
        stop = words_sent + count;
        while (words_sent < stop) begin
            ch = $urandom_range(0, NCH - 1);
            r  = $urandom_range(0, 99);
            if ((q_fill[ch] == DEPTH && r < 60) || r < 22) begin
                read_word(ch);
                if ($urandom_range(0, 1)) begin
                    read_word(ch);
                end
                send_word(FN_POP, 2'(ch), 8'($urandom), 8'($urandom));
            end else if (r < 30) begin
                send_noise_word(ch);
            end else begin
                send_frame(ch, pick_dest(), pick_len(), pick_fault(), 1'b1);
            end
        end
    endtask

    // Fills the channel queues in turn to the top, shows that further bytes are
    // refused, then reads and pops it back to empty. The first frame has
    // the longest payload.
    task automatic test_fill_and_drain(int count, int idle_pct);
        int         ch;
        int         stop;
        bit         long_done;
        logic [7:0] len;
        sender_idle_pct = idle_pct;
        stop      = words_sent + count;
        ch        = 0;
        long_done = 1'b0;
        while (words_sent < stop) begin
            while (q_fill[ch] < DEPTH) begin
                send_frame(ch, ($urandom_range(0, 1)) ? cfg_node : cfg_bcast,
                           long_done ? $urandom_range(0, 4) : 255, FAULT_NONE, 1'b0);
                long_done = 1'b1;
            end
            repeat (3) send_word(FN_RECEIVE, 2'(ch), 8'($urandom), 8'($urandom));
            while (q_fill[ch] > 0) begin
                len = slot_len[ch][q_head[ch]];
                send_word(FN_READ, 2'(ch), 8'($urandom), len - 8'd1);
                send_word(FN_READ, 2'(ch), 8'($urandom), len);
                read_word(ch);
                send_word(FN_POP, 2'(ch), 8'($urandom), 8'($urandom));
            end
            send_word(FN_POP, 2'(ch), 8'($urandom), 8'($urandom));
            ch = (ch + 1) % NCH;
        end
    endtask

    // ------------------------------------------------------------------
    // Block under test.
    // ------------------------------------------------------------------
    framed_packet_receiver_queue_unit #(
        .NUM_CHANNELS(NCH),
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_channel    (i_channel),
        .i_byte_value (i_byte_value),
        .i_data_index (i_data_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_dst_node   (o_dst_node),
        .o_src_node   (o_src_node),
        .o_frame_type (o_frame_type),
        .o_payload_len(o_payload_len),
        .o_data_byte  (o_data_byte)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // A result word is taken at the edge that closes its strobe cycle. The
    // values read here are those from before the edge, so the outcome does
    // not hang on the order of events within the step.
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing expected, status %0h",
                         $time, o_status);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 8'(want.status), 8'(o_status));
                compare_field("dst_node", want.dest, o_dst_node);
                compare_field("src_node", want.src, o_src_node);
                compare_field("frame_type", want.ftype, o_frame_type);
                compare_field("payload_len", want.len, o_payload_len);
                compare_field("data_byte", want.data, o_data_byte);
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset once, then the tests in turn, each under its own register
    // setting and a chosen sender pacing, the extreme address and head values among
    // them.
    initial begin
        clear_model();
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();

        apply_settings(8'h3C, 8'hFF, 8'hAA, 8'h55);
        test_random_traffic(500, 0);

        apply_settings(8'hFF, 8'h00, 8'hFF, 8'h00);
        test_random_traffic(450, 69);

        apply_settings(8'h00, 8'hFF, 8'h00, 8'hFF);
        test_fill_and_drain(350, 23);

        apply_settings(8'h81, 8'h7E, 8'h5A, 8'h5A);
        test_random_traffic(500, 23);

        wait_quiet();
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
